/* hdl/wpo_pkg.sv */
// ----------------------------------------------------------------------------
// wpo_pkg - peak overview shared definitions
// Sizes, full-scale codes and the beat and lane types used by the core.
// ----------------------------------------------------------------------------
package wpo_pkg;

  localparam int unsigned SAMPLE_BITS      = 16;
  localparam int unsigned INDEX_BITS       = 16;
  localparam int unsigned CHUNK_SAMPLES    = 64;
  localparam int unsigned CHUNKS_PER_GROUP = 8;

  localparam int unsigned SIC_W = $clog2(CHUNK_SAMPLES);
  localparam int unsigned CIG_W = $clog2(CHUNKS_PER_GROUP);

  // Result queue depth; must hold two beats above the admit limit
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [INDEX_BITS-1:0]         index_t;

  // +1.0 and -1.0 in signed Q1.15
  localparam sample_t SAMPLE_PLUS_ONE  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MINUS_ONE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic LEVEL_CHUNK = 1'b0;
  localparam logic LEVEL_GROUP = 1'b1;

  // Per-frame control shared by all lanes
  typedef struct packed {
    logic accept;
    logic close_chunk;
    logic close_group;
    logic clip_end;
  } wpo_lane_ctrl_t;

  // Folded extremes of one lane, including the current frame
  typedef struct packed {
    sample_t chunk_min;
    sample_t chunk_max;
    sample_t group_min;
    sample_t group_max;
  } wpo_lane_stat_t;

  typedef struct packed {
    logic    level;
    index_t  entry_index;
    sample_t left_min;
    sample_t left_max;
    sample_t right_min;
    sample_t right_max;
    logic    last_of_run;
    logic    end_of_clip;
  } wpo_result_t;

endpackage

/* hdl/wpo_lane.sv */
// ----------------------------------------------------------------------------
// wpo_lane - one channel's min/max tracker
// Folds samples into chunk extremes and closed chunks into group extremes.
// ----------------------------------------------------------------------------
module wpo_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wpo_pkg::sample_t        sample_i,
  input  logic                    track_i,
  input  wpo_pkg::wpo_lane_ctrl_t ctrl_i,
  output wpo_pkg::wpo_lane_stat_t stat_o
);

  wpo_pkg::sample_t chunk_min_q, chunk_min_d;
  wpo_pkg::sample_t chunk_max_q, chunk_max_d;
  wpo_pkg::sample_t group_min_q, group_min_d;
  wpo_pkg::sample_t group_max_q, group_max_d;
  wpo_pkg::sample_t chunk_min_new, chunk_max_new;
  wpo_pkg::sample_t group_min_new, group_max_new;

  // Fold the frame, then the resulting chunk into the group
  always_comb begin
    chunk_min_new = chunk_min_q;
    chunk_max_new = chunk_max_q;
    if (track_i) begin
      if (sample_i < chunk_min_q) chunk_min_new = sample_i;
      if (sample_i > chunk_max_q) chunk_max_new = sample_i;
    end
    group_min_new = (chunk_min_new < group_min_q) ? chunk_min_new : group_min_q;
    group_max_new = (chunk_max_new > group_max_q) ? chunk_max_new : group_max_q;
  end

  always_comb begin
    chunk_min_d = chunk_min_q;
    chunk_max_d = chunk_max_q;
    group_min_d = group_min_q;
    group_max_d = group_max_q;
    if (ctrl_i.accept) begin
      if (ctrl_i.close_chunk) begin
        chunk_min_d = wpo_pkg::SAMPLE_PLUS_ONE;
        chunk_max_d = wpo_pkg::SAMPLE_MINUS_ONE;
        if (ctrl_i.close_group || ctrl_i.clip_end) begin
          group_min_d = wpo_pkg::SAMPLE_PLUS_ONE;
          group_max_d = wpo_pkg::SAMPLE_MINUS_ONE;
        end else begin
          group_min_d = group_min_new;
          group_max_d = group_max_new;
        end
      end else begin
        chunk_min_d = chunk_min_new;
        chunk_max_d = chunk_max_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_min_q <= wpo_pkg::SAMPLE_PLUS_ONE;
      chunk_max_q <= wpo_pkg::SAMPLE_MINUS_ONE;
      group_min_q <= wpo_pkg::SAMPLE_PLUS_ONE;
      group_max_q <= wpo_pkg::SAMPLE_MINUS_ONE;
    end else begin
      chunk_min_q <= chunk_min_d;
      chunk_max_q <= chunk_max_d;
      group_min_q <= group_min_d;
      group_max_q <= group_max_d;
    end
  end

  assign stat_o.chunk_min = chunk_min_new;
  assign stat_o.chunk_max = chunk_max_new;
  assign stat_o.group_min = group_min_new;
  assign stat_o.group_max = group_max_new;

endmodule

/* hdl/wpo_out_fifo.sv */
// ----------------------------------------------------------------------------
// wpo_out_fifo - result beat queue
// Takes up to two beats per cycle, hands out one per cycle while pop_i is high.
// ----------------------------------------------------------------------------
module wpo_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push0_i,
  input  logic                 push1_i,
  input  wpo_pkg::wpo_result_t item0_i,
  input  wpo_pkg::wpo_result_t item1_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 pop_i,
  output wpo_pkg::wpo_result_t item_o
);

  wpo_pkg::wpo_result_t slot_q [wpo_pkg::FIFO_DEPTH];
  logic [wpo_pkg::PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [wpo_pkg::CNT_W-1:0] count_q, count_d;
  logic                      pop;

  assign pop      = pop_i && valid_o;
  assign wr_ptr_nx = wr_ptr_q + wpo_pkg::PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push0_i) wr_ptr_d = wr_ptr_nx;
    if (push0_i && push1_i) wr_ptr_d = wr_ptr_q + wpo_pkg::PTR_W'(2);
    rd_ptr_d = pop ? rd_ptr_q + wpo_pkg::PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + wpo_pkg::CNT_W'(push0_i) + wpo_pkg::CNT_W'(push0_i && push1_i)
               - wpo_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) slot_q[wr_ptr_q] <= item0_i;
    if (push0_i && push1_i) slot_q[wr_ptr_nx] <= item1_i;
  end

  assign valid_o = (count_q != '0);
  assign room_o  = (count_q <= wpo_pkg::CNT_W'(wpo_pkg::FIFO_DEPTH - 2));
  assign item_o  = slot_q[rd_ptr_q];

endmodule

/* hdl/waveform_peak_overview_core.sv */
// ----------------------------------------------------------------------------
// waveform_peak_overview_core - two-level min/max peak overview
// Per-channel lanes fold frames into chunk and group extremes; a merge stage
// builds chunk and group result beats into a small output queue.
// ----------------------------------------------------------------------------
// Throughput: one frame per cycle while the queue has room; the queue drains
// one beat per cycle while m_axis_tready_i is high. A closing frame pushes its
// beats as it is accepted; one closing a group yields two beats, chunk first;
// the four-entry queue admits a frame only while two entries are free.
// Reset: asynchronous, active low; extremes return to +1.0/-1.0, counters to
// zero, queue empties, stereo_mode returns to 1. No clearing pass.
// ----------------------------------------------------------------------------
module waveform_peak_overview_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: stereo_mode
  input  logic        cfg_wr_en_i,
  input  logic        cfg_wr_data_i,
  // Frame input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // left_sample[15:0], right_sample[31:16]
  input  logic        s_axis_tlast_i,   // clip_end
  // Result output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // entry_index, left_min, left_max,
                                        // right_min, right_max (16 bits each)
  output logic        m_axis_tlast_o,   // last_of_run
  output logic [1:0]  m_axis_tuser_o    // level[0], end_of_clip[1]
);

  localparam int unsigned SB = wpo_pkg::SAMPLE_BITS;

  logic                          stereo_q;
  logic [wpo_pkg::SIC_W-1:0]     sample_in_chunk_q, sample_in_chunk_d;
  logic [wpo_pkg::CIG_W-1:0]     chunk_in_group_q, chunk_in_group_d;
  wpo_pkg::index_t               chunk_counter_q, chunk_counter_d;
  wpo_pkg::index_t               group_counter_q, group_counter_d;

  logic                          accept, clip_end, room;
  wpo_pkg::wpo_lane_ctrl_t       ctrl;
  wpo_pkg::wpo_lane_stat_t       left_stat, right_stat;
  wpo_pkg::sample_t              left_sample, right_sample;
  wpo_pkg::wpo_result_t          chunk_res, group_res, out_item;

  assign left_sample  = s_axis_tdata_i[SB-1:0];
  assign right_sample = s_axis_tdata_i[2*SB-1:SB];
  assign clip_end     = s_axis_tlast_i;

  assign s_axis_tready_o = room;
  assign accept          = s_axis_tvalid_i && room;

  // Chunk closes on its last sample or early at clip end; group on its last chunk
  always_comb begin
    ctrl.accept      = accept;
    ctrl.clip_end    = clip_end;
    ctrl.close_chunk = clip_end ||
      (sample_in_chunk_q == wpo_pkg::SIC_W'(wpo_pkg::CHUNK_SAMPLES - 1));
    ctrl.close_group = ctrl.close_chunk &&
      (chunk_in_group_q == wpo_pkg::CIG_W'(wpo_pkg::CHUNKS_PER_GROUP - 1));
  end

  // Advance the position counters; clip end returns everything to zero
  always_comb begin
    sample_in_chunk_d = sample_in_chunk_q;
    chunk_in_group_d  = chunk_in_group_q;
    chunk_counter_d   = chunk_counter_q;
    group_counter_d   = group_counter_q;
    if (accept) begin
      if (clip_end) begin
        sample_in_chunk_d = '0;
        chunk_in_group_d  = '0;
        chunk_counter_d   = '0;
        group_counter_d   = '0;
      end else if (ctrl.close_chunk) begin
        sample_in_chunk_d = '0;
        chunk_counter_d   = chunk_counter_q + wpo_pkg::INDEX_BITS'(1);
        if (ctrl.close_group) begin
          chunk_in_group_d = '0;
          group_counter_d  = group_counter_q + wpo_pkg::INDEX_BITS'(1);
        end else begin
          chunk_in_group_d = chunk_in_group_q + wpo_pkg::CIG_W'(1);
        end
      end else begin
        sample_in_chunk_d = sample_in_chunk_q + wpo_pkg::SIC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stereo_q          <= 1'b1;
      sample_in_chunk_q <= '0;
      chunk_in_group_q  <= '0;
      chunk_counter_q   <= '0;
      group_counter_q   <= '0;
    end else begin
      if (cfg_wr_en_i) stereo_q <= cfg_wr_data_i;
      sample_in_chunk_q <= sample_in_chunk_d;
      chunk_in_group_q  <= chunk_in_group_d;
      chunk_counter_q   <= chunk_counter_d;
      group_counter_q   <= group_counter_d;
    end
  end

  // Lanes: left always tracked, right only in stereo
  wpo_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (left_sample),
    .track_i  (1'b1),
    .ctrl_i   (ctrl),
    .stat_o   (left_stat)
  );

  wpo_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (right_sample),
    .track_i  (stereo_q),
    .ctrl_i   (ctrl),
    .stat_o   (right_stat)
  );

  // Merge: combine lane extremes into chunk and group beats; zero right in mono.
  // The group beat, when present, is the last of the frame's run.
  always_comb begin
    chunk_res.level       = wpo_pkg::LEVEL_CHUNK;
    chunk_res.entry_index = chunk_counter_q;
    chunk_res.left_min    = left_stat.chunk_min;
    chunk_res.left_max    = left_stat.chunk_max;
    chunk_res.right_min   = stereo_q ? right_stat.chunk_min : '0;
    chunk_res.right_max   = stereo_q ? right_stat.chunk_max : '0;
    chunk_res.last_of_run = !ctrl.close_group;
    chunk_res.end_of_clip = !ctrl.close_group && clip_end;

    group_res.level       = wpo_pkg::LEVEL_GROUP;
    group_res.entry_index = group_counter_q;
    group_res.left_min    = left_stat.group_min;
    group_res.left_max    = left_stat.group_max;
    group_res.right_min   = stereo_q ? right_stat.group_min : '0;
    group_res.right_max   = stereo_q ? right_stat.group_max : '0;
    group_res.last_of_run = 1'b1;
    group_res.end_of_clip = clip_end;
  end

  wpo_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (accept && ctrl.close_chunk),
    .push1_i (ctrl.close_group),
    .item0_i (chunk_res),
    .item1_i (group_res),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .pop_i   (m_axis_tready_i),
    .item_o  (out_item)
  );

  assign m_axis_tdata_o = {out_item.right_max, out_item.right_min, out_item.left_max,
                           out_item.left_min, out_item.entry_index};
  assign m_axis_tlast_o = out_item.last_of_run;
  assign m_axis_tuser_o = {out_item.end_of_clip, out_item.level};

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - peak overview core testbench
// Streams stereo and mono clips into the core and checks every chunk and group
// beat against a bit-accurate software fold of the same frames. Random gaps on
// the frame side and random back-pressure on the result side exercise the
// handshakes; the stereo register is toggled between clips and in mid-clip.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int unsigned FRAME_TARGET = 900;
  localparam int unsigned CALM_AFTER   = 780;   // frames before back-pressure stops
  localparam int unsigned SETTLE_CYCLES = 4;    // pipeline settle before a register write

  // --------------------------------------------------------------------------
  // Scoreboard: folds accepted frames into expected overview entries and checks
  // every result beat against the oldest one still outstanding.
  // --------------------------------------------------------------------------
  class peak_scoreboard;
    wpo_pkg::wpo_result_t peak_entries_q[$];
    bit                   stereo;
    wpo_pkg::sample_t     chunk_lmin, chunk_lmax, chunk_rmin, chunk_rmax;
    wpo_pkg::sample_t     group_lmin, group_lmax, group_rmin, group_rmax;
    int unsigned          samples_in_chunk, chunks_in_group;
    wpo_pkg::index_t      chunk_idx, group_idx;
    int unsigned          mismatches, entries_checked;
    int unsigned          chunk_entries, group_entries, short_chunks, clips;

    function new();
      stereo = 1'b1;
      clear_chunk();
      clear_group();
      chunk_idx = '0;
      group_idx = '0;
    endfunction

    function void clear_chunk();
      chunk_lmin = wpo_pkg::SAMPLE_PLUS_ONE;
      chunk_lmax = wpo_pkg::SAMPLE_MINUS_ONE;
      chunk_rmin = wpo_pkg::SAMPLE_PLUS_ONE;
      chunk_rmax = wpo_pkg::SAMPLE_MINUS_ONE;
      samples_in_chunk = 0;
    endfunction

    function void clear_group();
      group_lmin = wpo_pkg::SAMPLE_PLUS_ONE;
      group_lmax = wpo_pkg::SAMPLE_MINUS_ONE;
      group_rmin = wpo_pkg::SAMPLE_PLUS_ONE;
      group_rmax = wpo_pkg::SAMPLE_MINUS_ONE;
      chunks_in_group = 0;
    endfunction

    function wpo_pkg::sample_t lo(wpo_pkg::sample_t a, wpo_pkg::sample_t b);
      return (a < b) ? a : b;
    endfunction

    function wpo_pkg::sample_t hi(wpo_pkg::sample_t a, wpo_pkg::sample_t b);
      return (a > b) ? a : b;
    endfunction

    // Right extremes are reported only if stereo is on when the entry is closed
    function wpo_pkg::wpo_result_t make_entry(logic lvl, wpo_pkg::index_t idx,
                                              wpo_pkg::sample_t lmin,
                                              wpo_pkg::sample_t lmax,
                                              wpo_pkg::sample_t rmin,
                                              wpo_pkg::sample_t rmax);
      wpo_pkg::wpo_result_t e;
      e.level       = lvl;
      e.entry_index = idx;
      e.left_min    = lmin;
      e.left_max    = lmax;
      e.right_min   = stereo ? rmin : wpo_pkg::sample_t'(0);
      e.right_max   = stereo ? rmax : wpo_pkg::sample_t'(0);
      e.last_of_run = 1'b0;
      e.end_of_clip = 1'b0;
      return e;
    endfunction

    function void fold_frame(wpo_pkg::sample_t l, wpo_pkg::sample_t r, bit clip_end);
      wpo_pkg::wpo_result_t e;
      chunk_lmin = lo(chunk_lmin, l);
      chunk_lmax = hi(chunk_lmax, l);
      if (stereo) begin
        chunk_rmin = lo(chunk_rmin, r);
        chunk_rmax = hi(chunk_rmax, r);
      end
      samples_in_chunk++;
      if (samples_in_chunk >= wpo_pkg::CHUNK_SAMPLES || clip_end) begin
        if (samples_in_chunk < wpo_pkg::CHUNK_SAMPLES) short_chunks++;
        e = make_entry(wpo_pkg::LEVEL_CHUNK, chunk_idx, chunk_lmin, chunk_lmax,
                       chunk_rmin, chunk_rmax);
        chunk_entries++;
        group_lmin = lo(group_lmin, chunk_lmin);
        group_lmax = hi(group_lmax, chunk_lmax);
        group_rmin = lo(group_rmin, chunk_rmin);
        group_rmax = hi(group_rmax, chunk_rmax);
        chunk_idx++;
        chunks_in_group++;
        clear_chunk();
        if (chunks_in_group >= wpo_pkg::CHUNKS_PER_GROUP) begin
          // chunk beat goes first, the group beat closes the run
          peak_entries_q.push_back(e);
          e = make_entry(wpo_pkg::LEVEL_GROUP, group_idx, group_lmin, group_lmax,
                         group_rmin, group_rmax);
          group_entries++;
          group_idx++;
          clear_group();
        end
        e.last_of_run = 1'b1;
        e.end_of_clip = clip_end;
        peak_entries_q.push_back(e);
      end
      // clip end drops any unfinished group and rewinds the indexes
      if (clip_end) begin
        clear_chunk();
        clear_group();
        chunk_idx = '0;
        group_idx = '0;
        clips++;
      end
    endfunction

    function void note_error(string what, logic [15:0] want, logic [15:0] seen);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on beat %0d, %s: expected %h, got %h",
                 entries_checked, what, want, seen);
    endfunction

    function void check_entry(wpo_pkg::wpo_result_t seen);
      wpo_pkg::wpo_result_t want;
      entries_checked++;
      if (peak_entries_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat %0d: level %0b index %0d", entries_checked,
                   seen.level, seen.entry_index);
        return;
      end
      want = peak_entries_q.pop_front();
      if (want.level !== seen.level)             note_error("level", 16'(want.level),
                                                            16'(seen.level));
      if (want.entry_index !== seen.entry_index) note_error("entry_index", want.entry_index,
                                                            seen.entry_index);
      if (want.left_min !== seen.left_min)       note_error("left_min", want.left_min,
                                                            seen.left_min);
      if (want.left_max !== seen.left_max)       note_error("left_max", want.left_max,
                                                            seen.left_max);
      if (want.right_min !== seen.right_min)     note_error("right_min", want.right_min,
                                                            seen.right_min);
      if (want.right_max !== seen.right_max)     note_error("right_max", want.right_max,
                                                            seen.right_max);
      if (want.last_of_run !== seen.last_of_run) note_error("last_of_run",
                                                            16'(want.last_of_run),
                                                            16'(seen.last_of_run));
      if (want.end_of_clip !== seen.end_of_clip) note_error("end_of_clip",
                                                            16'(want.end_of_clip),
                                                            16'(seen.end_of_clip));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT hookup
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  peak_scoreboard sb = new();
  bit             calm_tail = 1'b0;   // no gaps and no back-pressure once set
  bit             cur_stereo = 1'b1;
  int unsigned    frames_sent = 0;
  int unsigned    mode_writes = 0;
  int unsigned    idle_cycles = 0;

  always #4 clk = ~clk;

  waveform_peak_overview_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),    // left_sample[15:0], right_sample[31:16]
    .s_axis_tlast_i  (s_tlast),    // clip_end
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),    // entry_index, left_min, left_max, right_min, right_max
    .m_axis_tlast_o  (m_tlast),    // last_of_run
    .m_axis_tuser_o  (m_tuser)     // level[0], end_of_clip[1]
  );

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes and the register write at the rising edge.
  // Frames are folded before result beats are checked, so a same-edge result
  // would still find its expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    wpo_pkg::wpo_result_t seen;
    if (rst_n) begin
      if (cfg_wr_en) sb.stereo = cfg_wr_data;
      if (s_tvalid && s_tready)
        sb.fold_frame(wpo_pkg::sample_t'(s_tdata[15:0]),
                      wpo_pkg::sample_t'(s_tdata[31:16]), s_tlast);
      if (m_tvalid && m_tready) begin
        seen.level       = m_tuser[0];
        seen.end_of_clip = m_tuser[1];
        seen.last_of_run = m_tlast;
        seen.entry_index = m_tdata[15:0];
        seen.left_min    = m_tdata[31:16];
        seen.left_max    = m_tdata[47:32];
        seen.right_min   = m_tdata[63:48];
        seen.right_max   = m_tdata[79:64];
        sb.check_entry(seen);
      end
    end
  end

  // Watchdog: give up when neither side has moved a beat for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side back-pressure: random stall bursts, none in the calm tail
  initial begin
    int stall_len;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        stall_len = $urandom_range(1, 18);
        repeat (stall_len - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Present one frame, with an occasional gap first; return on acceptance
  task automatic send_frame(wpo_pkg::sample_t l, wpo_pkg::sample_t r, bit clip_end);
    int gap;
    @(negedge clk);
    if (!calm_tail && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r, l};
    s_tlast  <= clip_end;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    frames_sent++;
  endtask

  // Write stereo_mode once the core is idle: drop valid, drain, let it settle
  task automatic write_stereo(bit mode);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.peak_entries_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cur_stereo = mode;
    mode_writes++;
  endtask

  // Bias towards full-scale codes and small values around zero
  function automatic wpo_pkg::sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return wpo_pkg::SAMPLE_MINUS_ONE;
      1:       return wpo_pkg::SAMPLE_PLUS_ONE;
      2:       return wpo_pkg::sample_t'($signed($urandom_range(0, 64)) - 32);
      default: return wpo_pkg::sample_t'($urandom());
    endcase
  endfunction

  // Clip lengths aimed at the chunk and group boundaries
  function automatic int unsigned pick_clip_len();
    case ($urandom_range(0, 15))
      8, 9:    return $urandom_range(9, 130);
      10:      return wpo_pkg::CHUNK_SAMPLES * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
      // group closes on clip end
      11:      return wpo_pkg::CHUNK_SAMPLES * wpo_pkg::CHUNKS_PER_GROUP;
      12:      return wpo_pkg::CHUNK_SAMPLES * (wpo_pkg::CHUNKS_PER_GROUP - 1) +
                      $urandom_range(1, 63);
      13:      return wpo_pkg::CHUNK_SAMPLES * wpo_pkg::CHUNKS_PER_GROUP +
                      $urandom_range(1, 100);
      14:      return wpo_pkg::CHUNK_SAMPLES * $urandom_range(4, wpo_pkg::CHUNKS_PER_GROUP - 1);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned clip_len;
    int          switch_at;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: one-frame clips at full scale, the reset extremes must not leak
    send_frame(wpo_pkg::SAMPLE_MINUS_ONE, wpo_pkg::SAMPLE_PLUS_ONE, 1'b1);
    send_frame(wpo_pkg::SAMPLE_PLUS_ONE, wpo_pkg::SAMPLE_MINUS_ONE, 1'b1);
    // short final chunk with mixed signs, unfinished group dropped
    send_frame(16'sd0, 16'sd0, 1'b0);
    send_frame(wpo_pkg::SAMPLE_PLUS_ONE, -16'sd1, 1'b0);
    send_frame(-16'sd1, wpo_pkg::SAMPLE_PLUS_ONE, 1'b1);
    // mono: right extremes read as zero
    write_stereo(1'b0);
    send_frame(16'sd5, wpo_pkg::SAMPLE_MINUS_ONE, 1'b0);
    send_frame(wpo_pkg::SAMPLE_MINUS_ONE, wpo_pkg::SAMPLE_PLUS_ONE, 1'b1);
    // mono to stereo mid-clip: only later frames reach the right extremes
    send_frame(16'sd100, 16'sd200, 1'b0);
    write_stereo(1'b1);
    send_frame(-16'sd200, -16'sd300, 1'b1);
    // stereo to mono mid-clip: right fields zeroed on the way out
    send_frame(16'sd1, 16'sd2, 1'b0);
    write_stereo(1'b0);
    send_frame(16'sd3, 16'sd4, 1'b1);
    write_stereo(1'b1);
    send_frame(16'sh5555, 16'shAAAA, 1'b0);
    send_frame(16'shAAAA, 16'sh5555, 1'b1);

    // Random clips; trim the last one so the frame count lands on the target
    while (frames_sent < FRAME_TARGET) begin
      clip_len = pick_clip_len();
      if (clip_len > FRAME_TARGET - frames_sent) clip_len = FRAME_TARGET - frames_sent;
      if ($urandom_range(0, 3) == 0) write_stereo($urandom_range(0, 1));
      switch_at = (clip_len > 1 && $urandom_range(0, 4) == 0) ?
                  $urandom_range(1, clip_len - 1) : -1;
      for (int unsigned i = 0; i < clip_len; i++) begin
        if (i == switch_at) write_stereo(!cur_stereo);
        if (frames_sent >= CALM_AFTER) calm_tail = 1'b1;
        send_frame(pick_sample(), pick_sample(), i == clip_len - 1);
      end
    end

    // Drain, then keep watching the output to catch stray beats
    @(negedge clk);
    s_tvalid <= 1'b0;
    calm_tail = 1'b1;
    while (sb.peak_entries_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Ran %0d frames in %0d clips with %0d stereo mode writes.",
             frames_sent, sb.clips, mode_writes);
    $display("Checked %0d beats: %0d chunk (%0d cut short by clip end), %0d group.",
             sb.entries_checked, sb.chunk_entries, sb.short_chunks, sb.group_entries);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
